// ===== hdl/arnp_pkg.sv =====
package arnp_pkg;

	localparam int unsigned ValueWidth = 32;
	localparam int unsigned CountWidth = 8;
	localparam int unsigned DigitWidth = 5;

	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_MINUS = 8'h2d;
	localparam logic [7:0] CH_LO_X  = 8'h78;
	localparam logic [7:0] CH_UP_X  = 8'h58;
	localparam logic [7:0] CH_LO_B  = 8'h62;
	localparam logic [7:0] CH_UP_B  = 8'h42;
	localparam logic [7:0] CH_LO_A  = 8'h61;
	localparam logic [7:0] CH_LO_F  = 8'h66;
	localparam logic [7:0] CH_UP_A  = 8'h41;
	localparam logic [7:0] CH_UP_F  = 8'h46;

	localparam logic [DigitWidth-1:0] NO_DIGIT   = 5'd16;
	localparam logic [DigitWidth-1:0] DIGIT_B    = 5'd11;
	localparam logic [CountWidth-1:0] COUNT_MAX  = 8'hff;

	localparam logic STATUS_OK  = 1'b0;
	localparam logic STATUS_NAN = 1'b1;

	typedef enum logic [3:0] {
		PH_IDLE  = 4'd0,
		PH_ZERO  = 4'd1,
		PH_NEG0  = 4'd2,
		PH_NEG   = 4'd3,
		PH_HEXP  = 4'd4,
		PH_HEXD  = 4'd5,
		PH_BIN   = 4'd6,
		PH_OCT   = 4'd7,
		PH_PLAIN = 4'd8
	} phase_t;

	typedef struct packed {
		logic [7:0] ch;
		logic       start_req;
	} item_t;

	typedef struct packed {
		logic signed [ValueWidth-1:0] value;
		logic                         status;
		logic [CountWidth-1:0]        used_len;
	} result_t;

	function automatic logic [DigitWidth-1:0] digit_of(input logic [7:0] c);
		logic [DigitWidth-1:0] d;
		d = NO_DIGIT;
		if (c >= CH_ZERO && c <= CH_NINE) begin
			d = DigitWidth'(c - CH_ZERO);
		end else if (c >= CH_LO_A && c <= CH_LO_F) begin
			d = DigitWidth'(c - CH_LO_A + 8'd10);
		end else if (c >= CH_UP_A && c <= CH_UP_F) begin
			d = DigitWidth'(c - CH_UP_A + 8'd10);
		end
		return d;
	endfunction

endpackage

// ===== hdl/auto_radix_number_parser.sv =====
// Integer literal parser with automatic radix: one character is taken per
// cycle, with start_req marking the first character of a token. Hex, decimal,
// octal and binary values are built side by side and the radix is chosen when
// the first character that cannot extend the token arrives; that character
// ends the token, is accepted but not counted in its length, and the single
// result (value modulo 2^32, status, length saturating at 255) appears in the
// result register on the next cycle. A character is accepted every cycle unless a finished result is
// held by a stalled output; the result register is the only buffer between
// the two sides, so throughput is one character per clock.
module auto_radix_number_parser (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_stall,
	input  arnp_pkg::item_t   item,
	output logic              result_valid,
	input  logic              result_stall,
	output arnp_pkg::result_t result
);

	localparam int unsigned VW = arnp_pkg::ValueWidth;
	localparam int unsigned CW = arnp_pkg::CountWidth;
	localparam int unsigned DW = arnp_pkg::DigitWidth;

	arnp_pkg::phase_t  phase_q, b_phase, n_phase;
	logic [VW-1:0]     hex_q, dec_q, oct_q, bin_q;
	logic [VW-1:0]     b_hex, b_dec, b_oct, b_bin;
	logic [VW-1:0]     n_hex, n_dec, n_oct, n_bin;
	logic              letter_q, eight_q, above_q;
	logic              b_letter, b_eight, b_above;
	logic              n_letter, n_eight, n_above;
	logic [CW-1:0]     cnt_q, b_cnt, n_cnt, cnt_inc;

	logic              accept;
	logic [DW-1:0]     dig;
	logic              is_dig, is_dec, do_take, emit;
	arnp_pkg::result_t e_res;
	arnp_pkg::result_t result_q;
	logic              result_valid_q;

	assign item_stall   = result_valid_q & result_stall;
	assign accept       = item_valid & ~item_stall;
	assign result_valid = result_valid_q;
	assign result       = result_q;

	assign dig    = arnp_pkg::digit_of(item.ch);
	assign is_dig = dig != arnp_pkg::NO_DIGIT;
	assign is_dec = dig < DW'(10);

	always_comb begin
		if (item.start_req) begin
			b_phase  = arnp_pkg::PH_IDLE;
			b_hex    = '0;
			b_dec    = '0;
			b_oct    = '0;
			b_bin    = '0;
			b_letter = 1'b0;
			b_eight  = 1'b0;
			b_above  = 1'b0;
			b_cnt    = '0;
		end else begin
			b_phase  = phase_q;
			b_hex    = hex_q;
			b_dec    = dec_q;
			b_oct    = oct_q;
			b_bin    = bin_q;
			b_letter = letter_q;
			b_eight  = eight_q;
			b_above  = above_q;
			b_cnt    = cnt_q;
		end
		cnt_inc  = (b_cnt == arnp_pkg::COUNT_MAX) ? b_cnt : b_cnt + CW'(1);

		n_phase  = b_phase;
		n_hex    = b_hex;
		n_dec    = b_dec;
		n_oct    = b_oct;
		n_bin    = b_bin;
		n_letter = b_letter;
		n_eight  = b_eight;
		n_above  = b_above;
		n_cnt    = b_cnt;
		do_take  = 1'b0;
		emit     = 1'b0;
		e_res.value    = '0;
		e_res.status   = arnp_pkg::STATUS_NAN;
		e_res.used_len = '0;

		if (item.start_req) begin
			if (item.ch == arnp_pkg::CH_ZERO) begin
				n_cnt   = CW'(1);
				n_phase = arnp_pkg::PH_ZERO;
			end else if (item.ch == arnp_pkg::CH_MINUS) begin
				n_cnt   = CW'(1);
				n_phase = arnp_pkg::PH_NEG0;
			end else if (is_dig) begin
				do_take = 1'b1;
				n_phase = arnp_pkg::PH_PLAIN;
			end else begin
				emit = 1'b1;
			end
		end else begin
			case (b_phase)
				arnp_pkg::PH_ZERO: begin
					if (item.ch == arnp_pkg::CH_LO_X || item.ch == arnp_pkg::CH_UP_X) begin
						n_cnt   = CW'(2);
						n_phase = arnp_pkg::PH_HEXP;
					end else if (item.ch == arnp_pkg::CH_LO_B || item.ch == arnp_pkg::CH_UP_B) begin
						n_cnt   = CW'(2);
						n_hex   = VW'(arnp_pkg::DIGIT_B);
						n_phase = arnp_pkg::PH_BIN;
					end else if (is_dig) begin
						do_take = 1'b1;
						n_phase = arnp_pkg::PH_OCT;
					end else begin
						emit           = 1'b1;
						e_res.status   = arnp_pkg::STATUS_OK;
						e_res.used_len = b_cnt;
					end
				end
				arnp_pkg::PH_NEG0: begin
					if (is_dec) begin
						n_dec   = VW'(dig);
						n_cnt   = CW'(2);
						n_phase = arnp_pkg::PH_NEG;
					end else begin
						emit = 1'b1;
					end
				end
				arnp_pkg::PH_NEG: begin
					if (is_dec) begin
						n_dec = (b_dec << 3) + (b_dec << 1) + VW'(dig);
						n_cnt = cnt_inc;
					end else begin
						emit           = 1'b1;
						e_res.value    = -b_dec;
						e_res.status   = arnp_pkg::STATUS_OK;
						e_res.used_len = b_cnt;
					end
				end
				arnp_pkg::PH_HEXP: begin
					if (is_dig) begin
						n_hex   = VW'(dig);
						n_cnt   = CW'(3);
						n_phase = arnp_pkg::PH_HEXD;
					end else begin
						emit = 1'b1;
					end
				end
				arnp_pkg::PH_HEXD: begin
					if (is_dig) begin
						n_hex = (b_hex << 4) + VW'(dig);
						n_cnt = cnt_inc;
					end else begin
						emit           = 1'b1;
						e_res.value    = b_hex;
						e_res.status   = arnp_pkg::STATUS_OK;
						e_res.used_len = b_cnt;
					end
				end
				arnp_pkg::PH_BIN: begin
					if (is_dig) begin
						do_take = 1'b1;
					end else begin
						emit = 1'b1;
						if (b_letter || b_above) begin
							e_res.value    = b_hex;
							e_res.status   = arnp_pkg::STATUS_OK;
							e_res.used_len = b_cnt;
						end else if (b_cnt > CW'(2)) begin
							e_res.value    = b_bin;
							e_res.status   = arnp_pkg::STATUS_OK;
							e_res.used_len = b_cnt;
						end
					end
				end
				arnp_pkg::PH_OCT: begin
					if (is_dig) begin
						do_take = 1'b1;
					end else begin
						emit           = 1'b1;
						e_res.status   = arnp_pkg::STATUS_OK;
						e_res.used_len = b_cnt;
						if (b_letter) begin
							e_res.value = b_hex;
						end else if (!b_eight) begin
							e_res.value = b_oct;
						end else begin
							e_res.value = b_dec;
						end
					end
				end
				arnp_pkg::PH_PLAIN: begin
					if (is_dig) begin
						do_take = 1'b1;
					end else begin
						emit           = 1'b1;
						e_res.status   = arnp_pkg::STATUS_OK;
						e_res.used_len = b_cnt;
						e_res.value    = b_letter ? b_hex : b_dec;
					end
				end
				default: begin
					n_phase = arnp_pkg::PH_IDLE;
				end
			endcase
		end

		// accumulate one digit into the hex path, and a decimal digit also into the decimal, binary and (below 8) octal paths
		if (do_take) begin
			n_hex = (b_hex << 4) + VW'(dig);
			if (is_dec) begin
				n_dec = (b_dec << 3) + (b_dec << 1) + VW'(dig);
				if (dig < DW'(8)) begin
					n_oct = (b_oct << 3) + VW'(dig);
				end
				n_bin = {b_bin[VW-2:0], dig[0]};
				if (dig > DW'(7)) begin
					n_eight = 1'b1;
				end
				if (dig > DW'(1)) begin
					n_above = 1'b1;
				end
			end else begin
				n_letter = 1'b1;
			end
			n_cnt = cnt_inc;
		end

		if (emit) begin
			n_phase = arnp_pkg::PH_IDLE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= arnp_pkg::PH_IDLE;
			hex_q    <= '0;
			dec_q    <= '0;
			oct_q    <= '0;
			bin_q    <= '0;
			letter_q <= 1'b0;
			eight_q  <= 1'b0;
			above_q  <= 1'b0;
			cnt_q    <= '0;
		end else if (accept) begin
			phase_q  <= n_phase;
			hex_q    <= n_hex;
			dec_q    <= n_dec;
			oct_q    <= n_oct;
			bin_q    <= n_bin;
			letter_q <= n_letter;
			eight_q  <= n_eight;
			above_q  <= n_above;
			cnt_q    <= n_cnt;
		end
	end

	// result register, loaded when it is empty or its transfer completes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (accept && emit) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && emit) begin
			result_q <= e_res;
		end
	end

endmodule
